/* src/cpu8_pkg.sv */
// Shared types, opcode constants and flag helpers for the 8-bit CPU subset execute unit.
package cpu8_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_IX_BASE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IY_BASE = 1'd1;

  // Register codes as they appear in opcode bits 5:3 and 2:0.
  localparam logic [2:0] REG_B   = 3'd0;
  localparam logic [2:0] REG_C   = 3'd1;
  localparam logic [2:0] REG_D   = 3'd2;
  localparam logic [2:0] REG_E   = 3'd3;
  localparam logic [2:0] REG_H   = 3'd4;
  localparam logic [2:0] REG_L   = 3'd5;
  localparam logic [2:0] REG_MEM = 3'd6;
  localparam logic [2:0] REG_A   = 3'd7;

  localparam logic [2:0] DEST_NONE = 3'd0;
  localparam logic [2:0] DEST_A    = 3'd7;

  // Opcodes and opcode patterns.
  localparam logic [7:0] OP_LD_MASK     = 8'hC7;
  localparam logic [7:0] OP_LD_MATCH    = 8'h06;
  localparam logic [7:0] OP_INCDEC_MASK = 8'hC6;
  localparam logic [7:0] OP_INCDEC_MATCH = 8'h04;
  localparam logic [7:0] OP_ADD_FIRST   = 8'h80;
  localparam logic [7:0] OP_ADD_LAST    = 8'h85;
  localparam logic [7:0] OP_DJNZ        = 8'h10;
  localparam logic [7:0] OP_PREFIX_IX   = 8'hDD;
  localparam logic [7:0] OP_PREFIX_IY   = 8'hFD;
  localparam logic [7:0] SUB_INC_INDEX  = 8'h34;

  // Flag bit positions.
  localparam int FLAG_S  = 7;
  localparam int FLAG_Z  = 6;
  localparam int FLAG_H  = 4;
  localparam int FLAG_PV = 2;
  localparam int FLAG_N  = 1;
  localparam int FLAG_C  = 0;

  localparam logic [7:0] BYTE_MAX_POS = 8'h7F;
  localparam logic [7:0] BYTE_MIN_NEG = 8'h80;
  localparam logic [3:0] NIBBLE_ONES  = 4'b1111;

  typedef struct packed {
    logic [7:0]        kind;
    logic [7:0]        imm_byte;
    logic signed [7:0] displacement;
    logic [7:0]        mem_read_data;
  } item_t;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [7:0]  e;
    logic [7:0]  h;
    logic [7:0]  l;
    logic [7:0]  flags;
    logic [15:0] pc;
    logic [15:0] ix;
    logic [15:0] iy;
  } arch_t;

  typedef struct packed {
    logic        reg_we;
    logic [2:0]  reg_code;
    logic [7:0]  reg_value;
    logic [7:0]  flags;
    logic [15:0] pc;
  } wb_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [7:0]  flags_value;
    logic [2:0]  dest_index;
    logic [7:0]  dest_value;
    logic        mem_write;
    logic [15:0] mem_address;
    logic [7:0]  mem_write_data;
    logic        branch_taken;
  } result_t;

  function automatic logic [7:0] reg_read(input arch_t st, input logic [2:0] code);
    logic [7:0] v;
    case (code)
      REG_B:   v = st.b;
      REG_C:   v = st.c;
      REG_D:   v = st.d;
      REG_E:   v = st.e;
      REG_H:   v = st.h;
      REG_L:   v = st.l;
      REG_A:   v = st.a;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] dest_of(input logic [2:0] code);
    return (code == REG_A) ? DEST_A : code + 3'd1;
  endfunction

  function automatic logic [7:0] inc_flags(input logic [7:0] v, input logic [7:0] r,
                                           input logic carry);
    logic [7:0] f;
    f          = 8'h00;
    f[FLAG_C]  = carry;
    f[FLAG_S]  = r[7];
    f[FLAG_Z]  = (r == 8'h00);
    f[FLAG_H]  = (v[3:0] == NIBBLE_ONES);
    f[FLAG_PV] = (v == BYTE_MAX_POS);
    return f;
  endfunction

  function automatic logic [7:0] dec_flags(input logic [7:0] v, input logic [7:0] r,
                                           input logic carry);
    logic [7:0] f;
    f          = 8'h00;
    f[FLAG_C]  = carry;
    f[FLAG_N]  = 1'b1;
    f[FLAG_S]  = r[7];
    f[FLAG_Z]  = (r == 8'h00);
    f[FLAG_H]  = (v[3:0] == 4'd0);
    f[FLAG_PV] = (v == BYTE_MIN_NEG);
    return f;
  endfunction

endpackage

/* src/cpu8_if.sv */
// Valid/ready channel interfaces for instruction items and execution results.
interface cpu8_item_if;
  logic              valid;
  logic              ready;
  logic [7:0]        kind;
  logic [7:0]        imm_byte;
  logic signed [7:0] displacement;
  logic [7:0]        mem_read_data;

  modport source(output valid, output kind, output imm_byte, output displacement,
                 output mem_read_data, input ready);
  modport sink(input valid, input kind, input imm_byte, input displacement,
               input mem_read_data, output ready);
endinterface

interface cpu8_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic [7:0]  flags_value;
  logic [2:0]  dest_index;
  logic [7:0]  dest_value;
  logic        mem_write;
  logic [15:0] mem_address;
  logic [7:0]  mem_write_data;
  logic        branch_taken;

  modport source(output valid, output next_pc, output flags_value, output dest_index,
                 output dest_value, output mem_write, output mem_address,
                 output mem_write_data, output branch_taken, input ready);
  modport sink(input valid, input next_pc, input flags_value, input dest_index,
               input dest_value, input mem_write, input mem_address,
               input mem_write_data, input branch_taken, output ready);
endinterface

/* src/cpu8_state.sv */
// Architectural register file: A, B-L, flags, PC and the IX/IY configuration bases.
module cpu8_state (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [cpu8_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cpu8_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                commit,
  input  cpu8_pkg::wb_t                       wb,
  output cpu8_pkg::arch_t                     arch
);
  import cpu8_pkg::*;

  arch_t st;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_IX_BASE: st.ix <= cfg_data;
          CFG_IY_BASE: st.iy <= cfg_data;
          default: ;
        endcase
      end
      if (commit) begin
        st.flags <= wb.flags;
        st.pc    <= wb.pc;
        if (wb.reg_we) begin
          case (wb.reg_code)
            REG_B:   st.b <= wb.reg_value;
            REG_C:   st.c <= wb.reg_value;
            REG_D:   st.d <= wb.reg_value;
            REG_E:   st.e <= wb.reg_value;
            REG_H:   st.h <= wb.reg_value;
            REG_L:   st.l <= wb.reg_value;
            REG_A:   st.a <= wb.reg_value;
            default: ;
          endcase
        end
      end
    end
  end

  assign arch = st;

endmodule

/* src/cpu8_exec.sv */
// Single-pass decode and execute of one instruction against the current register state.
module cpu8_exec (
  input  cpu8_pkg::item_t   item,
  input  cpu8_pkg::arch_t   arch,
  output cpu8_pkg::wb_t     wb,
  output cpu8_pkg::result_t res
);
  import cpu8_pkg::*;

  logic [7:0]  op;
  logic [2:0]  code;
  logic        is_ld;
  logic        is_incdec;
  logic        is_add;
  logic        is_prefix;
  logic        is_djnz;
  logic        is_inc;
  logic [7:0]  operand;
  logic [7:0]  v;
  logic [7:0]  r;
  logic [8:0]  sum;
  logic        half;
  logic [15:0] pc_step;
  logic [15:0] base;

  always_comb begin
    op        = item.kind;
    code      = op[5:3];
    is_ld     = ((op & OP_LD_MASK) == OP_LD_MATCH) && (code != REG_MEM);
    is_incdec = ((op & OP_INCDEC_MASK) == OP_INCDEC_MATCH);
    is_add    = (op inside {[OP_ADD_FIRST:OP_ADD_LAST]});
    is_prefix = (op == OP_PREFIX_IX) || (op == OP_PREFIX_IY);
    is_djnz   = (op == OP_DJNZ);
    is_inc    = ~op[0];
    operand   = reg_read(arch, is_add ? op[2:0] : code);
    v         = (code == REG_MEM) ? item.mem_read_data : operand;
    r         = is_inc ? v + 8'd1 : v - 8'd1;
    sum       = {1'b0, arch.a} + {1'b0, operand};
    half      = ({1'b0, arch.a[3:0]} + {1'b0, operand[3:0]}) > {1'b0, NIBBLE_ONES};
    base      = (op == OP_PREFIX_IX) ? arch.ix : arch.iy;

    wb.reg_we    = 1'b0;
    wb.reg_code  = REG_B;
    wb.reg_value = 8'h00;
    wb.flags     = arch.flags;
    pc_step      = 16'd1;

    res.mem_write      = 1'b0;
    res.mem_address    = 16'h0000;
    res.mem_write_data = 8'h00;
    res.branch_taken   = 1'b0;

    if (is_ld) begin
      wb.reg_we    = 1'b1;
      wb.reg_code  = code;
      wb.reg_value = item.imm_byte;
      pc_step      = 16'd2;
    end else if (is_incdec) begin
      wb.flags = is_inc ? inc_flags(v, r, arch.flags[FLAG_C])
                        : dec_flags(v, r, arch.flags[FLAG_C]);
      if (code == REG_MEM) begin
        res.mem_write      = 1'b1;
        res.mem_address    = {arch.h, arch.l};
        res.mem_write_data = r;
      end else begin
        wb.reg_we    = 1'b1;
        wb.reg_code  = code;
        wb.reg_value = r;
      end
    end else if (is_add) begin
      wb.reg_we           = 1'b1;
      wb.reg_code         = REG_A;
      wb.reg_value        = sum[7:0];
      wb.flags            = 8'h00;
      wb.flags[FLAG_S]    = sum[7];
      wb.flags[FLAG_Z]    = (sum[7:0] == 8'h00);
      wb.flags[FLAG_H]    = half;
      wb.flags[FLAG_PV]   = (arch.a[7] == operand[7]) && (sum[7] != arch.a[7]);
      wb.flags[FLAG_C]    = sum[8];
    end else if (is_prefix) begin
      pc_step = 16'd3;
      if (item.imm_byte == SUB_INC_INDEX) begin
        res.mem_write      = 1'b1;
        res.mem_address    = base + {{8{item.displacement[7]}}, item.displacement};
        res.mem_write_data = item.mem_read_data + 8'd1;
        wb.flags = inc_flags(item.mem_read_data, item.mem_read_data + 8'd1,
                             arch.flags[FLAG_C]);
      end
    end else if (is_djnz) begin
      wb.reg_we    = 1'b1;
      wb.reg_code  = REG_B;
      wb.reg_value = arch.b - 8'd1;
      pc_step      = 16'd2;
      if (arch.b != 8'd1) begin
        res.branch_taken = 1'b1;
        pc_step          = 16'd2 + {{8{item.imm_byte[7]}}, item.imm_byte};
      end
    end

    wb.pc = arch.pc + pc_step;

    res.next_pc     = wb.pc;
    res.flags_value = wb.flags;
    res.dest_index  = wb.reg_we ? dest_of(wb.reg_code) : DEST_NONE;
    res.dest_value  = wb.reg_we ? wb.reg_value : 8'h00;
  end

endmodule

/* src/cpu8_inc_dec_add_djnz_unit.sv */
// Top level of the 8-bit CPU subset execute unit: input stage, execute and result register.
//
// The unit executes one decoded instruction per transaction on the item channel
// (opcode, following byte, displacement and the memory byte at the effective address)
// and returns one transaction on the result channel with the new PC, the flag byte,
// the register written, and any memory write request. A, B-L, flags and PC live here.
//
// Timing: an accepted item is held in the input register, where it is decoded and
// executed; when the result register can take it, the architectural state updates and
// the result register loads at the same edge. Throughput is one instruction per cycle
// while the receiver does not stall. Back-to-back items see each other's register
// writes because the state commits at the same edge that the next item enters
// execution.
//
// When the receiver stalls, a finished result waits in the result register while one
// more item is still accepted into the input register; ready drops only when both
// are full. Synchronous reset empties both stages and clears all registers, flags,
// the PC and the IX/IY bases. The IX/IY bases are written through the configuration
// port and should only change while no instruction is in flight.
module cpu8_inc_dec_add_djnz_unit (
  input  logic                              clk,
  input  logic                              rst,
  cpu8_item_if.sink                         item,
  cpu8_result_if.source                     result,
  input  logic                              cfg_write_en,
  input  logic [cpu8_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cpu8_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cpu8_pkg::*;

  logic    s1_valid;
  item_t   s1_item;
  logic    s1_go;
  logic    item_ready;
  logic    out_valid;
  result_t out_res;
  arch_t   arch;
  wb_t     wb;
  result_t exec_res;

  // The execute stage advances whenever the result register is empty or being drained.
  assign s1_go      = s1_valid && (!out_valid || result.ready);
  assign item_ready = !s1_valid || s1_go;
  assign item.ready = item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        s1_valid <= item.valid;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset; their valid bits qualify them.
  always_ff @(posedge clk) begin
    if (item_ready && item.valid) begin
      s1_item.kind          <= item.kind;
      s1_item.imm_byte      <= item.imm_byte;
      s1_item.displacement  <= item.displacement;
      s1_item.mem_read_data <= item.mem_read_data;
    end
    if (s1_go) begin
      out_res <= exec_res;
    end
  end

  cpu8_exec u_exec (
    .item (s1_item),
    .arch (arch),
    .wb   (wb),
    .res  (exec_res)
  );

  // State commits exactly when the executing instruction hands its result over.
  cpu8_state u_state (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .commit       (s1_go),
    .wb           (wb),
    .arch         (arch)
  );

  assign result.valid          = out_valid;
  assign result.next_pc        = out_res.next_pc;
  assign result.flags_value    = out_res.flags_value;
  assign result.dest_index     = out_res.dest_index;
  assign result.dest_value     = out_res.dest_value;
  assign result.mem_write      = out_res.mem_write;
  assign result.mem_address    = out_res.mem_address;
  assign result.mem_write_data = out_res.mem_write_data;
  assign result.branch_taken   = out_res.branch_taken;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the 8-bit CPU subset execute unit.
module tb;
  import cpu8_pkg::*;

  // Opcodes used by name in the directed table. The package gives the decode
  // patterns; these are the concrete instruction bytes picked out of them.
  localparam logic [7:0] OP_NOP        = 8'h00;
  localparam logic [7:0] OP_INC_B      = 8'h04;
  localparam logic [7:0] OP_LD_B_N     = 8'h06;
  localparam logic [7:0] OP_DEC_C      = 8'h0D;
  localparam logic [7:0] OP_LD_C_N     = 8'h0E;
  localparam logic [7:0] OP_LD_H_N     = 8'h26;
  localparam logic [7:0] OP_LD_L_N     = 8'h2E;
  localparam logic [7:0] OP_INC_MEM    = 8'h34;
  localparam logic [7:0] OP_DEC_MEM    = 8'h35;
  localparam logic [7:0] OP_LD_MEM_N   = 8'h36;
  localparam logic [7:0] OP_INC_A      = 8'h3C;
  localparam logic [7:0] OP_DEC_A      = 8'h3D;
  localparam logic [7:0] OP_LD_A_N     = 8'h3E;
  localparam logic [7:0] OP_ADD_A_B    = 8'h80;
  localparam logic [7:0] OP_ADD_A_C    = 8'h81;
  localparam logic [7:0] OP_ADD_A_L    = 8'h85;
  localparam logic [7:0] OP_ADD_A_MEM  = 8'h86;
  localparam logic [7:0] OP_ADD_A_A    = 8'h87;
  localparam logic [7:0] OP_UNDEFINED  = 8'hFF;
  localparam logic [7:0] SUB_UNDEFINED = 8'h00;

  localparam logic [2:0] DEST_B = 3'd1;

  // Cycles waited after the last expected result so that the pipeline settles.
  localparam int SETTLE_CYCLES    = 4;
  // Cycles without any transaction on either channel before the run is given up.
  localparam int STALL_LIMIT      = 1000;
  // One long receiver hold-off, started once this many results have arrived.
  localparam int LONG_HOLD_AT     = 250;
  localparam int LONG_HOLD_CYCLES = 48;
  localparam int PHASE_ITEMS      = 135;
  localparam int NUM_PHASES       = 5;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  cpu8_item_if   item_ch ();
  cpu8_result_if res_ch ();

  cpu8_inc_dec_add_djnz_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item         (item_ch),
    .result       (res_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the architectural state. Registers are indexed by their opcode
  // code, so B..L sit at 0..5, A at 7, and slot 6 (the memory operand) is unused.
  logic [7:0]  shadow_regs [0:7];
  logic [7:0]  shadow_flags;
  logic [15:0] shadow_pc;
  logic [15:0] shadow_ix;
  logic [15:0] shadow_iy;

  // Results predicted for accepted instructions, oldest first.
  result_t expected_results [$];

  typedef struct {
    item_t   insn;
    bit      typed;
    result_t want;
  } dir_row_t;
  dir_row_t directed_rows [$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int stall_cycles   = 0;
  int stall_left     = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  bit quiet_mode     = 1'b0;

  function automatic logic [7:0] inc_with_flags(input logic [7:0] v);
    logic [7:0] r;
    logic [7:0] f;
    r          = v + 8'd1;
    f          = 8'h00;
    f[FLAG_C]  = shadow_flags[FLAG_C];
    f[FLAG_S]  = r[7];
    f[FLAG_Z]  = (r == 8'h00);
    f[FLAG_H]  = (v[3:0] == 4'hF);
    f[FLAG_PV] = (v == BYTE_MAX_POS);
    shadow_flags = f;
    return r;
  endfunction

  function automatic logic [7:0] dec_with_flags(input logic [7:0] v);
    logic [7:0] r;
    logic [7:0] f;
    r          = v - 8'd1;
    f          = 8'h00;
    f[FLAG_C]  = shadow_flags[FLAG_C];
    f[FLAG_N]  = 1'b1;
    f[FLAG_S]  = r[7];
    f[FLAG_Z]  = (r == 8'h00);
    f[FLAG_H]  = (v[3:0] == 4'h0);
    f[FLAG_PV] = (v == BYTE_MIN_NEG);
    shadow_flags = f;
    return r;
  endfunction

  function automatic logic [2:0] dest_for(input logic [2:0] code);
    return (code == REG_A) ? DEST_A : code + 3'd1;
  endfunction

  // Executes one instruction on the shadow state and returns the result it causes.
  function automatic result_t execute_insn(input item_t insn);
    result_t     r;
    logic [2:0]  code;
    logic [15:0] step;
    logic [7:0]  v;
    logic [7:0]  addend;
    logic [8:0]  wide;
    logic [4:0]  low_sum;
    logic [15:0] base;
    r    = '0;
    code = insn.kind[5:3];
    step = 16'd1;
    if ((insn.kind & OP_LD_MASK) == OP_LD_MATCH && code != REG_MEM) begin
      shadow_regs[code] = insn.imm_byte;
      r.dest_index = dest_for(code);
      r.dest_value = insn.imm_byte;
      step = 16'd2;
    end else if ((insn.kind & OP_INCDEC_MASK) == OP_INCDEC_MATCH) begin
      v = (code == REG_MEM) ? insn.mem_read_data : shadow_regs[code];
      v = insn.kind[0] ? dec_with_flags(v) : inc_with_flags(v);
      if (code == REG_MEM) begin
        r.mem_write      = 1'b1;
        r.mem_address    = {shadow_regs[REG_H], shadow_regs[REG_L]};
        r.mem_write_data = v;
      end else begin
        shadow_regs[code] = v;
        r.dest_index = dest_for(code);
        r.dest_value = v;
      end
    end else if (insn.kind >= OP_ADD_FIRST && insn.kind <= OP_ADD_LAST) begin
      addend  = shadow_regs[insn.kind[2:0]];
      wide    = {1'b0, shadow_regs[REG_A]} + {1'b0, addend};
      low_sum = {1'b0, shadow_regs[REG_A][3:0]} + {1'b0, addend[3:0]};
      shadow_flags           = 8'h00;
      shadow_flags[FLAG_S]   = wide[7];
      shadow_flags[FLAG_Z]   = (wide[7:0] == 8'h00);
      shadow_flags[FLAG_H]   = low_sum[4];
      shadow_flags[FLAG_PV]  = (shadow_regs[REG_A][7] == addend[7]) && (wide[7] != addend[7]);
      shadow_flags[FLAG_C]   = wide[8];
      shadow_regs[REG_A]     = wide[7:0];
      r.dest_index = DEST_A;
      r.dest_value = wide[7:0];
    end else if (insn.kind == OP_PREFIX_IX || insn.kind == OP_PREFIX_IY) begin
      step = 16'd3;
      if (insn.imm_byte == SUB_INC_INDEX) begin
        base = (insn.kind == OP_PREFIX_IX) ? shadow_ix : shadow_iy;
        r.mem_write      = 1'b1;
        r.mem_address    = base + {{8{insn.displacement[7]}}, insn.displacement};
        r.mem_write_data = inc_with_flags(insn.mem_read_data);
      end
    end else if (insn.kind == OP_DJNZ) begin
      shadow_regs[REG_B] = shadow_regs[REG_B] - 8'd1;
      r.dest_index = dest_for(REG_B);
      r.dest_value = shadow_regs[REG_B];
      step = 16'd2;
      if (shadow_regs[REG_B] != 8'h00) begin
        step = 16'd2 + {{8{insn.imm_byte[7]}}, insn.imm_byte};
        r.branch_taken = 1'b1;
      end
    end
    shadow_pc     = shadow_pc + step;
    r.next_pc     = shadow_pc;
    r.flags_value = shadow_flags;
    return r;
  endfunction

  // Random instruction, weighted toward the instructions that do something, with
  // the rest of the byte space as noise. Operand bytes are random; a prefix mostly gets INC (IX+d).
  function automatic item_t random_insn();
    item_t      insn;
    int         pick;
    logic [2:0] code;
    insn.imm_byte      = 8'($urandom);
    insn.displacement  = 8'($urandom);
    insn.mem_read_data = 8'($urandom);
    pick = $urandom_range(0, 99);
    code = 3'($urandom_range(0, 7));
    if (pick < 15) begin
      if (code == REG_MEM) code = REG_A;
      insn.kind = OP_LD_MATCH | {2'b00, code, 3'b000};
    end else if (pick < 40) begin
      insn.kind = OP_INCDEC_MATCH | {2'b00, code, 3'b000} | {7'd0, ($urandom_range(0, 1) == 1)};
    end else if (pick < 55) begin
      insn.kind = OP_ADD_FIRST | {5'd0, code};
    end else if (pick < 65) begin
      insn.kind = OP_DJNZ;
    end else if (pick < 80) begin
      insn.kind = ($urandom_range(0, 1) == 1) ? OP_PREFIX_IX : OP_PREFIX_IY;
      if ($urandom_range(0, 4) != 0) insn.imm_byte = SUB_INC_INDEX;
    end else begin
      insn.kind = 8'($urandom);
    end
    return insn;
  endfunction

  function automatic void add_row(input item_t insn, input bit typed, input result_t want);
    dir_row_t row;
    row.insn  = insn;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // Compares one result transaction against the oldest expectation.
  function automatic void check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("ERROR: unexpected result pc=%h flags=%h dst=%0d val=%h", got.next_pc,
                 got.flags_value, got.dest_index, got.dest_value);
      return;
    end
    want = expected_results.pop_front();
    if (got.next_pc !== want.next_pc || got.flags_value !== want.flags_value ||
        got.dest_index !== want.dest_index || got.dest_value !== want.dest_value ||
        got.mem_write !== want.mem_write || got.mem_address !== want.mem_address ||
        got.mem_write_data !== want.mem_write_data || got.branch_taken !== want.branch_taken)
    begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display({"ERROR: result %0d mismatch\n",
                  "  expected pc=%h flags=%h dst=%0d val=%h mw=%b addr=%h wdata=%h br=%b\n",
                  "  actual   pc=%h flags=%h dst=%0d val=%h mw=%b addr=%h wdata=%h br=%b"},
                 results_seen,
                 want.next_pc, want.flags_value, want.dest_index, want.dest_value,
                 want.mem_write, want.mem_address, want.mem_write_data, want.branch_taken,
                 got.next_pc, got.flags_value, got.dest_index, got.dest_value,
                 got.mem_write, got.mem_address, got.mem_write_data, got.branch_taken);
    end
  endfunction

  // Writes one index base register. The write enable is a one-cycle strobe that is low
  // again when the task returns, so back-to-back calls never assign it twice in one time step.
  task automatic write_base(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == CFG_IX_BASE) shadow_ix = value;
    else shadow_iy = value;
    @(posedge clk);
  endtask

  // Offers one instruction and holds it until the unit takes it. The expectation is
  // either the typed-in one from the directed table or the shadow model's.
  task automatic send_insn(input item_t insn, input bit typed, input result_t want);
    result_t predicted;
    item_ch.valid         <= 1'b1;
    item_ch.kind          <= insn.kind;
    item_ch.imm_byte      <= insn.imm_byte;
    item_ch.displacement  <= insn.displacement;
    item_ch.mem_read_data <= insn.mem_read_data;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predicted = execute_insn(insn);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // Occasionally drops valid for a random burst of cycles between transactions.
  task automatic sender_gap();
    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Waits until every expected result has arrived, then lets the pipeline settle.
  task automatic drain_results();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side. Every edge it checks the transaction that just completed, then
  // decides ready for the next cycle: a single long hold-off once enough results
  // have come back, short random stall bursts otherwise, none in the quiet phase.
  always @(posedge clk) begin : result_sink
    result_t got;
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = {res_ch.next_pc, res_ch.flags_value, res_ch.dest_index, res_ch.dest_value,
               res_ch.mem_write, res_ch.mem_address, res_ch.mem_write_data,
               res_ch.branch_taken};
        check_result(got);
        results_seen++;
      end
      if (!hold_done && results_seen >= LONG_HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Counts cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("** cpu8_inc_dec_add_djnz_unit: FAILED **");
    $finish;
  end

  // Stimulus. After reset the index bases are set to their extremes and a short
  // directed table runs; then several random phases follow, each preceded by new
  // index bases written while the unit is empty. The last phase runs with no idling
  // on either side so back-to-back throughput is exercised.
  initial begin
    rst                   = 1'b1;
    cfg_write_en          = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    item_ch.valid         = 1'b0;
    item_ch.kind          = '0;
    item_ch.imm_byte      = '0;
    item_ch.displacement  = '0;
    item_ch.mem_read_data = '0;
    for (int i = 0; i < 8; i++) shadow_regs[i] = 8'h00;
    shadow_flags = 8'h00;
    shadow_pc    = 16'h0000;
    shadow_ix    = 16'h0000;
    shadow_iy    = 16'h0000;

    // Directed table: {opcode, following byte, displacement, memory byte}. Typed
    // results are {next pc, flags, dest, dest value, mem write, address, data, branch}.
    // The first rows start from the reset state, so their results are written out.
    add_row({OP_NOP, 8'h00, 8'h00, 8'h00}, 1'b1,
            {16'h0001, 8'h00, DEST_NONE, 8'h00, 1'b0, 16'h0000, 8'h00, 1'b0});
    add_row({OP_LD_B_N, 8'hFF, 8'h00, 8'h00}, 1'b1,
            {16'h0003, 8'h00, DEST_B, 8'hFF, 1'b0, 16'h0000, 8'h00, 1'b0});
    // B wraps from FF to 00: zero and half carry set.
    add_row({OP_INC_B, 8'h00, 8'h00, 8'h00}, 1'b1,
            {16'h0004, 8'h50, DEST_B, 8'h00, 1'b0, 16'h0000, 8'h00, 1'b0});
    // A load leaves the flags alone.
    add_row({OP_LD_A_N, 8'h7F, 8'h00, 8'h00}, 1'b1,
            {16'h0006, 8'h50, DEST_A, 8'h7F, 1'b0, 16'h0000, 8'h00, 1'b0});
    // 7F + 1 overflows into the sign bit; 80 - 1 overflows back.
    add_row({OP_INC_A, 8'h00, 8'h00, 8'h00}, 1'b1,
            {16'h0007, 8'h94, DEST_A, 8'h80, 1'b0, 16'h0000, 8'h00, 1'b0});
    add_row({OP_DEC_A, 8'h00, 8'h00, 8'h00}, 1'b1,
            {16'h0008, 8'h16, DEST_A, 8'h7F, 1'b0, 16'h0000, 8'h00, 1'b0});
    // ADD producing zero with carry out, then a DEC that must keep that carry.
    add_row({OP_LD_C_N, 8'h81, 8'h00, 8'h00}, 1'b0, '0);
    add_row({OP_ADD_A_C, 8'h00, 8'h00, 8'h00}, 1'b0, '0);
    add_row({OP_DEC_C, 8'h00, 8'h00, 8'h00}, 1'b0, '0);
    // Memory forms through HL, checking the byte order of the address.
    add_row({OP_LD_H_N, 8'h12, 8'h00, 8'h00}, 1'b0, '0);
    add_row({OP_LD_L_N, 8'h34, 8'h00, 8'h00}, 1'b0, '0);
    add_row({OP_INC_MEM, 8'h00, 8'h00, 8'hFF}, 1'b0, '0);
    add_row({OP_DEC_MEM, 8'h00, 8'h00, 8'h00}, 1'b0, '0);
    add_row({OP_ADD_A_B, 8'h00, 8'h00, 8'h00}, 1'b0, '0);
    add_row({OP_ADD_A_L, 8'h00, 8'h00, 8'h00}, 1'b0, '0);
    // ADD A,(HL) and ADD A,A are outside the set and must behave as no-ops.
    add_row({OP_ADD_A_MEM, 8'h00, 8'h00, 8'h00}, 1'b0, '0);
    add_row({OP_ADD_A_A, 8'h00, 8'h00, 8'h00}, 1'b0, '0);
    // DJNZ with B at zero wraps to FF and jumps the full distance backward;
    // with B at one it falls through.
    add_row({OP_DJNZ, 8'h80, 8'h00, 8'h00}, 1'b0, '0);
    add_row({OP_LD_B_N, 8'h01, 8'h00, 8'h00}, 1'b0, '0);
    add_row({OP_DJNZ, 8'h7F, 8'h00, 8'h00}, 1'b0, '0);
    // Indexed increments: IX at FFFF plus one wraps to zero, IY at zero minus 128.
    add_row({OP_PREFIX_IX, SUB_INC_INDEX, 8'h01, 8'h7F}, 1'b0, '0);
    add_row({OP_PREFIX_IY, SUB_INC_INDEX, 8'h80, 8'h00}, 1'b0, '0);
    // Unknown sub-opcode after a prefix, LD (HL),n, and an unused opcode.
    add_row({OP_PREFIX_IX, SUB_UNDEFINED, 8'h7F, 8'hFF}, 1'b0, '0);
    add_row({OP_LD_MEM_N, 8'hA5, 8'h00, 8'h00}, 1'b0, '0);
    add_row({OP_UNDEFINED, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_base(CFG_IX_BASE, 16'hFFFF);
    write_base(CFG_IY_BASE, 16'h0000);
    foreach (directed_rows[i]) begin
      send_insn(directed_rows[i].insn, directed_rows[i].typed, directed_rows[i].want);
      sender_gap();
    end
    // The sender pauses here until the unit has returned every result.
    item_ch.valid <= 1'b0;
    drain_results();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1: begin
          write_base(CFG_IX_BASE, 16'h0000);
          write_base(CFG_IY_BASE, 16'hFFFF);
        end
        NUM_PHASES - 1: begin
          write_base(CFG_IX_BASE, 16'h8000);
          write_base(CFG_IY_BASE, 16'h7FFF);
        end
        default: begin
          write_base(CFG_IX_BASE, 16'($urandom));
          write_base(CFG_IY_BASE, 16'($urandom));
        end
      endcase
      quiet_mode = (phase == NUM_PHASES - 1);
      repeat (PHASE_ITEMS) begin
        send_insn(random_insn(), 1'b0, '0);
        sender_gap();
      end
      item_ch.valid <= 1'b0;
      drain_results();
    end

    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("** cpu8_inc_dec_add_djnz_unit: PASSED **");
    else
      $display("** cpu8_inc_dec_add_djnz_unit: FAILED **");
    $finish;
  end

endmodule
